// ===== rtl/hsowr_pkg.sv =====
// shared types, register codes and reset constants for the single-wire sensor reader
// no dependencies; imported by every module of the block
package hsowr_pkg;

	localparam int FRAME_BYTES_DEF = 5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_LOW    = 3'd0,
		REG_RELEASE      = 3'd1,
		REG_RESP_TIMEOUT = 3'd2,
		REG_PHASE_TIMEOUT = 3'd3,
		REG_BIT_SAMPLE   = 3'd4
	} reg_idx_t;

	localparam logic [15:0] START_LOW_RST     = 16'd20000;
	localparam logic [7:0]  RELEASE_RST       = 8'd30;
	localparam logic [7:0]  RESP_TIMEOUT_RST  = 8'd100;
	localparam logic [7:0]  PHASE_TIMEOUT_RST = 8'd50;
	localparam logic [7:0]  BIT_SAMPLE_RST    = 8'd40;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_RESP   = 3'd1;
	localparam logic [2:0] ST_RESP_LOW  = 3'd2;
	localparam logic [2:0] ST_RESP_HIGH = 3'd3;
	localparam logic [2:0] ST_BIT_LOW   = 3'd4;
	localparam logic [2:0] ST_BIT_HIGH  = 3'd5;
	localparam logic [2:0] ST_CHECKSUM  = 3'd6;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_LOW = 4'd1,
		PH_RELEASE   = 4'd2,
		PH_WAIT_RESP = 4'd3,
		PH_RESP_LOW  = 4'd4,
		PH_RESP_HIGH = 4'd5,
		PH_BIT_LOW   = 4'd6,
		PH_BIT_WAIT  = 4'd7,
		PH_BIT_HIGH  = 4'd8
	} phase_t;

	typedef struct packed {
		logic [15:0] start_low_ticks;
		logic [7:0]  release_ticks;
		logic [7:0]  response_timeout;
		logic [7:0]  phase_timeout;
		logic [7:0]  bit_sample_ticks;
	} cfg_t;

	typedef struct packed {
		logic line_level;
		logic start_req;
	} in_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [2:0] status;
		logic [7:0] humidity_int;
		logic [7:0] humidity_frac;
		logic [7:0] temperature_int;
		logic [7:0] temperature_frac;
	} out_t;

endpackage

// ===== rtl/hsowr_cfg.sv =====
// configuration register bank of the single-wire sensor reader
// depends on hsowr_pkg
module hsowr_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hsowr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hsowr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output hsowr_pkg::cfg_t                   cfg
);
	import hsowr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks  <= START_LOW_RST;
			cfg_q.release_ticks    <= RELEASE_RST;
			cfg_q.response_timeout <= RESP_TIMEOUT_RST;
			cfg_q.phase_timeout    <= PHASE_TIMEOUT_RST;
			cfg_q.bit_sample_ticks <= BIT_SAMPLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_LOW:     cfg_q.start_low_ticks  <= cfg_data;
				REG_RELEASE:       cfg_q.release_ticks    <= cfg_data[7:0];
				REG_RESP_TIMEOUT:  cfg_q.response_timeout <= cfg_data[7:0];
				REG_PHASE_TIMEOUT: cfg_q.phase_timeout    <= cfg_data[7:0];
				REG_BIT_SAMPLE:    cfg_q.bit_sample_ticks <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/hsowr_in_reg.sv =====
// input register stage: holds one tick transaction until the sequencer takes it
// depends on hsowr_pkg
module hsowr_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  hsowr_pkg::in_t   in_data,
	input  logic             advance,
	output logic             item_valid,
	output hsowr_pkg::in_t   item
);
	import hsowr_pkg::*;

	logic valid_s1;
	in_t  data_s1;

	// a held item that cannot move on blocks the input
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	assign item_valid = valid_s1;
	assign item       = data_s1;

endmodule

// ===== rtl/hsowr_seq.sv =====
// reading sequencer: phase, tick counter, bit counter, frame shifter and status
// depends on hsowr_pkg; result is combinational from the next state
module hsowr_seq #(
	parameter int FRAME_BYTES = hsowr_pkg::FRAME_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  hsowr_pkg::in_t   item,
	input  hsowr_pkg::cfg_t  cfg,
	output hsowr_pkg::out_t  res
);
	import hsowr_pkg::*;

	localparam int TOTAL_BITS = 8 * FRAME_BYTES;
	localparam int FRAME_W    = TOTAL_BITS;
	localparam int BIT_W      = $clog2(TOTAL_BITS);

	phase_t             phase_q, phase_n;
	logic [15:0]        tick_q, tick_n;
	logic [BIT_W-1:0]   bit_idx_q, bit_idx_n;
	logic [FRAME_W-1:0] frame_q, frame_n;
	logic [2:0]         status_q, status_n;
	logic               done_n;

	logic [15:0]        tick_inc;
	logic [7:0]         limit;
	logic               wait_over;
	logic               last_bit;
	logic [7:0]         sum;
	logic [7:0]         data_byte [4];

	assign tick_inc  = tick_q + 16'd1;
	assign limit     = (phase_q == PH_WAIT_RESP) ? cfg.response_timeout : cfg.phase_timeout;
	assign wait_over = tick_inc > {8'd0, limit};
	assign last_bit  = ({1'b0, bit_idx_q} + (BIT_W+1)'(1)) >= (BIT_W+1)'(TOTAL_BITS);

	// 8-bit sum of every byte but the trailing checksum
	always_comb begin
		sum = '0;
		for (int k = 0; k < FRAME_BYTES - 1; k++) begin
			sum = sum + frame_q[FRAME_W-1-8*k -: 8];
		end
	end

	always_comb begin
		phase_n   = phase_q;
		tick_n    = tick_q;
		bit_idx_n = bit_idx_q;
		frame_n   = frame_q;
		status_n  = status_q;
		done_n    = 1'b0;
		unique case (phase_q) inside
			PH_IDLE: begin
				if (item.start_req) begin
					phase_n   = PH_START_LOW;
					tick_n    = 16'd1;
					bit_idx_n = '0;
					frame_n   = '0;
				end
			end
			PH_START_LOW: begin
				if (tick_q >= cfg.start_low_ticks) begin
					phase_n = PH_RELEASE;
					tick_n  = 16'd1;
				end else begin
					tick_n = tick_inc;
				end
			end
			PH_RELEASE: begin
				if (tick_q >= {8'd0, cfg.release_ticks}) begin
					phase_n = PH_WAIT_RESP;
					tick_n  = '0;
				end else begin
					tick_n = tick_inc;
				end
			end
			PH_WAIT_RESP, PH_RESP_HIGH: begin
				if (!item.line_level) begin
					phase_n = (phase_q == PH_WAIT_RESP) ? PH_RESP_LOW : PH_BIT_LOW;
					tick_n  = '0;
				end else if (wait_over) begin
					phase_n  = PH_IDLE;
					tick_n   = '0;
					status_n = (phase_q == PH_WAIT_RESP) ? ST_NO_RESP : ST_RESP_HIGH;
					done_n   = 1'b1;
				end else begin
					tick_n = tick_inc;
				end
			end
			PH_RESP_LOW, PH_BIT_LOW: begin
				if (item.line_level) begin
					phase_n = (phase_q == PH_RESP_LOW) ? PH_RESP_HIGH : PH_BIT_WAIT;
					tick_n  = '0;
				end else if (wait_over) begin
					phase_n  = PH_IDLE;
					tick_n   = '0;
					status_n = (phase_q == PH_RESP_LOW) ? ST_RESP_LOW : ST_BIT_LOW;
					done_n   = 1'b1;
				end else begin
					tick_n = tick_inc;
				end
			end
			PH_BIT_WAIT: begin
				tick_n = tick_inc;
				if (tick_inc >= {8'd0, cfg.bit_sample_ticks}) begin
					frame_n = {frame_q[FRAME_W-2:0], item.line_level};
					phase_n = PH_BIT_HIGH;
					tick_n  = '0;
				end
			end
			PH_BIT_HIGH: begin
				if (!item.line_level) begin
					if (last_bit) begin
						phase_n   = PH_IDLE;
						tick_n    = '0;
						bit_idx_n = '0;
						status_n  = (sum == frame_q[7:0]) ? ST_OK : ST_CHECKSUM;
						done_n    = 1'b1;
					end else begin
						bit_idx_n = bit_idx_q + BIT_W'(1);
						phase_n   = PH_BIT_LOW;
						tick_n    = '0;
					end
				end else if (wait_over) begin
					phase_n  = PH_IDLE;
					tick_n   = '0;
					status_n = ST_BIT_HIGH;
					done_n   = 1'b1;
				end else begin
					tick_n = tick_inc;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				tick_n  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			bit_idx_q <= '0;
			frame_q   <= '0;
			status_q  <= ST_OK;
		end else if (step) begin
			phase_q   <= phase_n;
			tick_q    <= tick_n;
			bit_idx_q <= bit_idx_n;
			frame_q   <= frame_n;
			status_q  <= status_n;
		end
	end

	// data bytes shown only for good or checksum-failed readings, never the checksum byte
	for (genvar k = 0; k < 4; k++) begin : g_byte
		if (k < FRAME_BYTES - 1) begin : g_have
			assign data_byte[k] = (status_n == ST_OK || status_n == ST_CHECKSUM)
				? frame_n[FRAME_W-1-8*k -: 8] : 8'd0;
		end else begin : g_none
			assign data_byte[k] = 8'd0;
		end
	end

	always_comb begin
		res.drive_low        = (phase_n == PH_START_LOW);
		res.busy_res         = (phase_n != PH_IDLE);
		res.done_res         = done_n;
		res.status           = status_n;
		res.humidity_int     = data_byte[0];
		res.humidity_frac    = data_byte[1];
		res.temperature_int  = data_byte[2];
		res.temperature_frac = data_byte[3];
	end

endmodule

// ===== rtl/hsowr_out_reg.sv =====
// result register: holds one result transaction until the receiver takes it
// depends on hsowr_pkg
module hsowr_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hsowr_pkg::out_t   res,
	output logic              out_valid,
	input  logic              out_stall,
	output hsowr_pkg::out_t   out_data
);
	import hsowr_pkg::*;

	logic valid_q;
	out_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== rtl/humidity_sensor_one_wire_reader.sv =====
// top level of the single-wire humidity and temperature sensor reader
// depends on hsowr_pkg, hsowr_cfg, hsowr_in_reg, hsowr_seq, hsowr_out_reg
//
//   channel   handshake              payload                  transaction
//   in        in_valid / in_stall    hsowr_pkg::in_t          one microsecond tick
//   out       out_valid / out_stall  hsowr_pkg::out_t         one result per tick
//   cfg       cfg_we                 cfg_index, cfg_data      one register write
//
// one tick transaction per cycle sustained while out_stall is low; an accepted tick is
// held in the input register and its result is then registered in the result register,
// from which the receiver takes it
// the sequencer state advances only when the held tick moves into the result register
// out_stall backs up through the input register; in_stall rises only while a tick is held
// asynchronous reset returns the sequencer to idle and the configuration registers to defaults
module humidity_sensor_one_wire_reader #(
	parameter int FRAME_BYTES = hsowr_pkg::FRAME_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  hsowr_pkg::in_t                    in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output hsowr_pkg::out_t                   out_data,
	input  logic                              cfg_we,
	input  logic [hsowr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hsowr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import hsowr_pkg::*;

	cfg_t cfg;
	in_t  item;
	out_t res;
	logic item_valid;
	logic advance;

	// held tick moves on when the result register is empty or being emptied
	assign advance = item_valid && (!out_valid || !out_stall);

	hsowr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hsowr_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	// phase sequencer; one step per tick transaction
	hsowr_seq #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item),
		.cfg    (cfg),
		.res    (res)
	);

	hsowr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	// a reading that has just ended is no longer busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done result still marked busy");

	// the line is only driven while a reading is in progress
	a_drive_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drive_low |-> out_data.busy_res)
		else $error("line driven low outside a reading");

	// the input only backs up while a tick is held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> item_valid && out_valid && out_stall)
		else $error("input stalled without a held tick");

	// timeouts clear the data fields
	a_timeout_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK && out_data.status != ST_CHECKSUM |->
		out_data.humidity_int == 8'd0 && out_data.humidity_frac == 8'd0 &&
		out_data.temperature_int == 8'd0 && out_data.temperature_frac == 8'd0)
		else $error("data shown after a timeout");
`endif

endmodule

// ===== tb/tb_humidity_sensor_one_wire_reader.sv =====
// self-checking testbench for humidity_sensor_one_wire_reader
// depends on hsowr_pkg and the rtl of the block; a behavioral sensor drives the line
// while a tick-exact predictor of the reader checks every per-tick result
module tb_humidity_sensor_one_wire_reader;
	import hsowr_pkg::*;

	localparam int NBYTES      = FRAME_BYTES_DEF;
	localparam int FRAME_BITS  = 8 * NBYTES;
	// watchdog limit on a stretch without any transaction
	localparam int QUIET_LIMIT = 2000;
	// random ticks; the reading in flight at the end adds a little more
	localparam int RAND_ITEMS  = 560;

	// kinds of sensor behavior for one reading
	localparam int RD_GOOD    = 0;
	localparam int RD_BAD_SUM = 1;
	localparam int RD_BROKEN  = 2;
	localparam int RD_NOISE   = 3;

	localparam out_t RES_IDLE = '0;

	// one row of the directed table: the tick and, where typed, its result
	typedef struct packed {
		logic line;
		logic start;
		logic typed;
		out_t res;
	} dir_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_t                   in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor state and register shadow
	cfg_t        reader_cfg;
	phase_t      pr_phase;
	logic [15:0] pr_ticks;
	logic [5:0]  pr_bit;
	logic [63:0] pr_frame;
	logic [2:0]  pr_status;
	logic        pr_sampled;
	logic        pr_done;

	out_t reader_outputs_due [$];
	out_t want_r;

	int  mismatches   = 0;
	int  quiet_cycles = 0;
	int  items_rand   = 0;
	int  tx_calm      = 0;
	int  rx_hold      = 0;
	int  rx_calm      = 0;
	bit  no_idle      = 1'b0;
	bit  counting     = 1'b0;
	bit  held_once    = 1'b0;

	dir_row_t dir_rows [25];

	humidity_sensor_one_wire_reader #(
		.FRAME_BYTES(NBYTES)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// byte k of the received frame, msb first
	function automatic logic [7:0] rx_byte(input int k);
		return pr_frame[8 * (NBYTES - 1 - k) +: 8];
	endfunction

	// reading over: latch the status and go back to idle
	function automatic void end_reading(input logic [2:0] code);
		pr_status = code;
		pr_phase  = PH_IDLE;
		pr_ticks  = '0;
		pr_done   = 1'b1;
	endfunction

	// one more tick at the same level; true once it lasted longer than the limit
	function automatic bit level_overrun(input logic [7:0] limit);
		pr_ticks = pr_ticks + 16'd1;
		return pr_ticks > {8'd0, limit};
	endfunction

	function automatic void enter_phase(input phase_t p);
		pr_phase = p;
		pr_ticks = '0;
	endfunction

	function automatic out_t predict_reader(input logic line, input logic start);
		logic [7:0] sum;
		logic [7:0] shown [4];
		out_t       r;
		sum     = '0;
		pr_done = 1'b0;
		case (pr_phase)
			PH_IDLE: begin
				if (start) begin
					pr_phase   = PH_START_LOW;
					pr_ticks   = 16'd1;
					pr_bit     = '0;
					pr_frame   = '0;
					pr_sampled = 1'b0;
				end
			end
			PH_START_LOW: begin
				if (pr_ticks >= reader_cfg.start_low_ticks) begin
					pr_phase = PH_RELEASE;
					pr_ticks = 16'd1;
				end else begin
					pr_ticks = pr_ticks + 16'd1;
				end
			end
			PH_RELEASE: begin
				if (pr_ticks >= {8'd0, reader_cfg.release_ticks}) enter_phase(PH_WAIT_RESP);
				else pr_ticks = pr_ticks + 16'd1;
			end
			PH_WAIT_RESP: begin
				if (!line) enter_phase(PH_RESP_LOW);
				else if (level_overrun(reader_cfg.response_timeout)) end_reading(ST_NO_RESP);
			end
			PH_RESP_LOW: begin
				if (line) enter_phase(PH_RESP_HIGH);
				else if (level_overrun(reader_cfg.phase_timeout)) end_reading(ST_RESP_LOW);
			end
			PH_RESP_HIGH: begin
				if (!line) enter_phase(PH_BIT_LOW);
				else if (level_overrun(reader_cfg.phase_timeout)) end_reading(ST_RESP_HIGH);
			end
			PH_BIT_LOW: begin
				if (line) enter_phase(PH_BIT_WAIT);
				else if (level_overrun(reader_cfg.phase_timeout)) end_reading(ST_BIT_LOW);
			end
			PH_BIT_WAIT: begin
				// sample point counts from the rising edge, zero behaves as one
				pr_ticks = pr_ticks + 16'd1;
				if (pr_ticks >= {8'd0, reader_cfg.bit_sample_ticks}) begin
					pr_sampled = line;
					pr_frame   = {pr_frame[62:0], line};
					enter_phase(PH_BIT_HIGH);
				end
			end
			PH_BIT_HIGH: begin
				if (!line) begin
					if (int'(pr_bit) + 1 >= FRAME_BITS) begin
						// last bit done: 8-bit sum of the data bytes against the checksum byte
						for (int k = 0; k < NBYTES - 1; k++) sum = sum + rx_byte(k);
						end_reading((sum == rx_byte(NBYTES - 1)) ? ST_OK : ST_CHECKSUM);
						pr_bit = '0;
					end else begin
						pr_bit = pr_bit + 6'd1;
						enter_phase(PH_BIT_LOW);
					end
				end else if (level_overrun(reader_cfg.phase_timeout)) begin
					end_reading(ST_BIT_HIGH);
				end
			end
			default: enter_phase(PH_IDLE);
		endcase

		// data shows only after a clean or checksum-failed reading, never the checksum byte
		for (int k = 0; k < 4; k++) begin
			shown[k] = '0;
			if ((pr_status == ST_OK || pr_status == ST_CHECKSUM) && k + 1 < NBYTES)
				shown[k] = rx_byte(k);
		end
		r.drive_low        = (pr_phase == PH_START_LOW);
		r.busy_res         = (pr_phase != PH_IDLE);
		r.done_res         = pr_done;
		r.status           = pr_status;
		r.humidity_int     = shown[0];
		r.humidity_frac    = shown[1];
		r.temperature_int  = shown[2];
		r.temperature_frac = shown[3];
		return r;
	endfunction

	// result of a tick that ends a reading with a timeout code
	function automatic out_t finished_with(input logic [2:0] code);
		return {3'b001, code, 32'd0};
	endfunction

	// ---------------------------------------------------------------- driving

	// one tick transaction; entered and left at a falling edge
	task automatic send_tick(input logic line, input logic start, input logic typed,
			input out_t typed_res, input bit hold);
		out_t p;
		if (tx_calm != 0) tx_calm--;
		else if ($urandom_range(0, 199) == 0) tx_calm = $urandom_range(50, 300);
		if (hold) begin
			// hold off until the block has handed back everything
			in_valid <= 1'b0;
			while (reader_outputs_due.size() != 0) @(negedge clk);
			@(negedge clk);
		end else if (!no_idle && tx_calm == 0 && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {line, start};
		do @(posedge clk); while (in_stall);
		p = predict_reader(line, start);
		reader_outputs_due.push_back(typed ? typed_res : p);
		if (counting) items_rand++;
		@(negedge clk);
	endtask

	// stop sending and let every pending result and the pipeline drain
	task automatic settle();
		in_valid <= 1'b0;
		while (reader_outputs_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// all five registers plus one write to an unused index, back to back
	task automatic write_regs(input cfg_t c);
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		cfg_we <= 1'b1;
		for (int i = 0; i < 6; i++) begin
			// 8-bit registers get random upper bits, which must be dropped
			case (i)
				0: begin idx = REG_START_LOW;     val = c.start_low_ticks; end
				1: begin idx = REG_RELEASE;       val = {8'($urandom), c.release_ticks}; end
				2: begin idx = REG_RESP_TIMEOUT;  val = {8'($urandom), c.response_timeout}; end
				3: begin idx = REG_PHASE_TIMEOUT; val = {8'($urandom), c.phase_timeout}; end
				4: begin idx = REG_BIT_SAMPLE;    val = {8'($urandom), c.bit_sample_ticks}; end
				default: begin
					idx = CFG_IDX_W'(int'(REG_BIT_SAMPLE) + 1 + int'($urandom_range(0, 2)));
					val = 16'($urandom);
				end
			endcase
			cfg_index <= idx;
			cfg_data  <= val;
			@(posedge clk);
			case (idx)
				REG_START_LOW:     reader_cfg.start_low_ticks  = val;
				REG_RELEASE:       reader_cfg.release_ticks    = val[7:0];
				REG_RESP_TIMEOUT:  reader_cfg.response_timeout = val[7:0];
				REG_PHASE_TIMEOUT: reader_cfg.phase_timeout    = val[7:0];
				REG_BIT_SAMPLE:    reader_cfg.bit_sample_ticks = val[7:0];
				default: ;
			endcase
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic cfg_t short_timing();
		cfg_t c;
		c.start_low_ticks  = 16'($urandom_range(0, 4));
		c.release_ticks    = 8'($urandom_range(0, 4));
		c.response_timeout = 8'($urandom_range(0, 8));
		c.phase_timeout    = 8'($urandom_range(0, 8));
		c.bit_sample_ticks = 8'($urandom_range(0, 3));
		return c;
	endfunction

	// how long the sensor keeps a level; the limit itself is the last legal length
	function automatic int level_len(input int limit, input bit brk);
		if (brk && $urandom_range(0, 24) == 0) return limit + 1;
		if ($urandom_range(0, 5) == 0) return limit;
		return $urandom_range(0, (limit < 3) ? limit : 3);
	endfunction

	// a sensor answering one start request, steered by the predicted phase
	task automatic run_reading(input int kind);
		logic [FRAME_BITS-1:0] pattern;
		logic [7:0]            sum;
		phase_t                seen;
		int                    cnt;
		int                    want;
		int                    hi_len;
		int                    limit;
		int                    smp;
		logic                  ln;
		logic                  bitv;
		bit                    hold;
		sum = '0;
		for (int k = 0; k < NBYTES - 1; k++) begin
			case ($urandom_range(0, 7))
				0:       pattern[8 * (NBYTES - 1 - k) +: 8] = 8'h00;
				1:       pattern[8 * (NBYTES - 1 - k) +: 8] = 8'hff;
				default: pattern[8 * (NBYTES - 1 - k) +: 8] = 8'($urandom);
			endcase
			sum = sum + pattern[8 * (NBYTES - 1 - k) +: 8];
		end
		// a wrong checksum always differs from the true sum
		pattern[7:0] = (kind == RD_BAD_SUM) ? (sum ^ 8'($urandom_range(1, 255))) : sum;

		seen = PH_IDLE;
		cnt  = 0;
		want = 0;
		hi_len = 0;
		send_tick(1'($urandom), 1'b1, 1'b0, RES_IDLE, 1'b0);
		while (pr_phase != PH_IDLE) begin
			if (pr_phase != seen) begin
				seen   = pr_phase;
				cnt    = 0;
				limit  = (pr_phase == PH_WAIT_RESP) ? int'(reader_cfg.response_timeout)
					: int'(reader_cfg.phase_timeout);
				smp    = (reader_cfg.bit_sample_ticks == 8'd0) ? 1
					: int'(reader_cfg.bit_sample_ticks);
				want   = level_len(limit, kind == RD_BROKEN);
				hi_len = $urandom_range(0, smp - 1);
			end
			bitv = pattern[FRAME_BITS - 1 - int'(pr_bit)];
			case (pr_phase) inside
				PH_WAIT_RESP, PH_RESP_HIGH: ln = (cnt < want);
				PH_RESP_LOW, PH_BIT_LOW:    ln = !(cnt < want);
				// a zero bit drops back low before the sample point
				PH_BIT_WAIT:                ln = bitv ? 1'b1 : (cnt < hi_len);
				PH_BIT_HIGH:                ln = bitv ? (cnt < want) : 1'b0;
				default:                    ln = 1'($urandom);
			endcase
			if (kind == RD_NOISE) ln = 1'($urandom);
			hold = 1'b0;
			if (!no_idle && !held_once && pr_phase == PH_BIT_LOW && pr_bit == 6'd20) begin
				hold      = 1'b1;
				held_once = 1'b1;
			end
			// start requests while busy must be ignored
			send_tick(ln, 1'($urandom), 1'b0, RES_IDLE, hold);
			cnt++;
		end
		repeat ($urandom_range(0, 3)) send_tick(1'($urandom), 1'b0, 1'b0, RES_IDLE, 1'b0);
	endtask

	function automatic int pick_kind();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) return RD_GOOD;
		if (r < 15) return RD_BAD_SUM;
		if (r < 18) return RD_BROKEN;
		return RD_NOISE;
	endfunction

	// receiver back-pressure: bursts of stall with calm stretches in between
	always @(negedge clk) begin
		if (no_idle) begin
			rx_hold = 0;
			out_stall <= 1'b0;
		end else if (rx_hold != 0) begin
			rx_hold--;
			out_stall <= 1'b1;
		end else if (rx_calm != 0) begin
			rx_calm--;
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 199) == 0) begin
			rx_calm = $urandom_range(50, 300);
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			rx_hold = $urandom_range(0, 9);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- checking

	task automatic cmp_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s: expected %0h, actual %0h", name, exp_v, got_v);
		end
	endtask

	// result transactions against the oldest expectation, plus the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (reader_outputs_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: result %0h with nothing expected", out_data);
				end else begin
					want_r = reader_outputs_due.pop_front();
					cmp_field("drive_low", 8'(want_r.drive_low), 8'(out_data.drive_low));
					cmp_field("busy_res", 8'(want_r.busy_res), 8'(out_data.busy_res));
					cmp_field("done_res", 8'(want_r.done_res), 8'(out_data.done_res));
					cmp_field("status", 8'(want_r.status), 8'(out_data.status));
					cmp_field("humidity_int", want_r.humidity_int, out_data.humidity_int);
					cmp_field("humidity_frac", want_r.humidity_frac, out_data.humidity_frac);
					cmp_field("temperature_int", want_r.temperature_int,
						out_data.temperature_int);
					cmp_field("temperature_frac", want_r.temperature_frac,
						out_data.temperature_frac);
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		cfg_t c;
		int   phase_reads;

		reader_cfg.start_low_ticks  = START_LOW_RST;
		reader_cfg.release_ticks    = RELEASE_RST;
		reader_cfg.response_timeout = RESP_TIMEOUT_RST;
		reader_cfg.phase_timeout    = PHASE_TIMEOUT_RST;
		reader_cfg.bit_sample_ticks = BIT_SAMPLE_RST;
		pr_phase   = PH_IDLE;
		pr_ticks   = '0;
		pr_bit     = '0;
		pr_frame   = '0;
		pr_status  = ST_OK;
		pr_sampled = 1'b0;
		pr_done    = 1'b0;

		// directed ticks under one-tick start and release, zero timeouts and zero sample delay
		dir_rows = '{
			{1'b1, 1'b0, 1'b1, RES_IDLE},                 // idle after reset
			// no response: line stays high after release
			{1'b0, 1'b1, 1'b0, RES_IDLE},
			{1'b1, 1'b1, 1'b0, RES_IDLE},                 // start while busy
			{1'b0, 1'b0, 1'b0, RES_IDLE},
			{1'b1, 1'b0, 1'b1, finished_with(ST_NO_RESP)},
			// response low too long
			{1'b1, 1'b1, 1'b0, RES_IDLE},
			{1'b0, 1'b0, 1'b0, RES_IDLE},
			{1'b1, 1'b0, 1'b0, RES_IDLE},
			{1'b0, 1'b0, 1'b0, RES_IDLE},
			{1'b0, 1'b1, 1'b1, finished_with(ST_RESP_LOW)},
			// response high too long
			{1'b1, 1'b1, 1'b0, RES_IDLE},
			{1'b1, 1'b0, 1'b0, RES_IDLE},
			{1'b1, 1'b0, 1'b0, RES_IDLE},
			{1'b0, 1'b0, 1'b0, RES_IDLE},
			{1'b1, 1'b0, 1'b0, RES_IDLE},
			{1'b1, 1'b0, 1'b1, finished_with(ST_RESP_HIGH)},
			// first data bit sampled high and held too long
			{1'b1, 1'b1, 1'b0, RES_IDLE},
			{1'b0, 1'b0, 1'b0, RES_IDLE},
			{1'b0, 1'b0, 1'b0, RES_IDLE},
			{1'b0, 1'b0, 1'b0, RES_IDLE},
			{1'b1, 1'b0, 1'b0, RES_IDLE},
			{1'b0, 1'b0, 1'b0, RES_IDLE},
			{1'b1, 1'b0, 1'b0, RES_IDLE},
			{1'b1, 1'b1, 1'b0, RES_IDLE},
			{1'b1, 1'b0, 1'b1, finished_with(ST_BIT_HIGH)}
		};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		c.start_low_ticks  = 16'd1;
		c.release_ticks    = 8'd1;
		c.response_timeout = 8'd0;
		c.phase_timeout    = 8'd0;
		c.bit_sample_ticks = 8'd0;
		write_regs(c);
		foreach (dir_rows[i])
			send_tick(dir_rows[i].line, dir_rows[i].start, dir_rows[i].typed,
				dir_rows[i].res, 1'b0);

		// random readings under a couple of short timing settings
		counting = 1'b1;
		for (int p = 0; p < 2; p++) begin
			settle();
			write_regs(short_timing());
			do run_reading(pick_kind()); while (items_rand < (p + 1) * RAND_ITEMS / 3);
		end

		// last stretch runs with both sides always ready
		settle();
		no_idle = 1'b1;
		write_regs(short_timing());
		phase_reads = 0;
		while (items_rand < RAND_ITEMS || phase_reads == 0) begin
			run_reading(pick_kind());
			phase_reads++;
		end

		settle();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && reader_outputs_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
